/* sv/integer_matrix_multiply_macros.svh */
// Assertion macros for the integer matrix multiplier.
// No dependencies; files that assert include this header by name.
`ifndef INTEGER_MATRIX_MULTIPLY_MACROS_SVH
`define INTEGER_MATRIX_MULTIPLY_MACROS_SVH

// Check a property at each rising clock edge outside reset.
`define IMM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds at a rising clock edge outside reset.
`define IMM_ASSERT_NEVER(label, clk, rst, cond, msg) \
   `IMM_ASSERT(label, clk, rst, !(cond), msg)

`endif

/* sv/imm_pkg.sv */
// Shared types, widths and codes of the integer matrix multiplier.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package imm_pkg;

   localparam int MAX_DIM_DEFAULT = 8;
   localparam int DIM_W      = 4;
   localparam int ROW_W      = 3;
   localparam int VALUE_W    = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   localparam logic [DIM_W-1:0] DIM_RESET = 4'd2;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B    = 2'd2;

   // Matrix select codes
   localparam logic MATRIX_A = 1'b0;
   localparam logic MATRIX_B = 1'b1;

   typedef struct packed {
      logic                      matrix_select;
      logic [ROW_W-1:0]          load_row;
      logic [ROW_W-1:0]          load_col;
      logic signed [VALUE_W-1:0] element_value;
      logic                      load_last;
   } req_word_type;

   typedef struct packed {
      logic [ROW_W-1:0]          out_row;
      logic [ROW_W-1:0]          out_col;
      logic signed [VALUE_W-1:0] product_value;
      logic                      out_last;
   } rsp_word_type;

   typedef struct packed {
      logic [DIM_W-1:0] rows_a;
      logic [DIM_W-1:0] inner_dim;
      logic [DIM_W-1:0] cols_b;
   } dims_type;

   // One multiply-accumulate step travelling down the datapath
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } tag_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_ISSUE,
      SEQ_DRAIN,
      SEQ_OUTPUT
   } seq_state_type;

endpackage

/* sv/imm_ram.sv */
// Single-write, single-read element store with registered read data.
// Depends on imm_pkg for the element width.
`timescale 1ns / 1ps

module imm_ram #(
   parameter int DEPTH  = imm_pkg::MAX_DIM_DEFAULT * imm_pkg::MAX_DIM_DEFAULT,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [ADDR_W-1:0]            wr_addr,
   input  logic [imm_pkg::VALUE_W-1:0]  wr_data,
   input  logic [ADDR_W-1:0]            rd_addr,
   output logic [imm_pkg::VALUE_W-1:0]  rd_data
);
   import imm_pkg::*;

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/imm_seq.sv */
// Sequencer of the matrix multiplier: walks row, column and inner index.
// Depends on imm_pkg for the dimension, tag and state types.
`timescale 1ns / 1ps

module imm_seq #(
   parameter int MAX_DIM = imm_pkg::MAX_DIM_DEFAULT,
   parameter int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
   parameter int ADDR_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  imm_pkg::dims_type         dims,
   input  logic                      done,
   input  logic                      rsp_ready,
   output logic                      req_ready,
   output logic                      rsp_valid,
   output logic [imm_pkg::ROW_W-1:0] rsp_row,
   output logic [imm_pkg::ROW_W-1:0] rsp_col,
   output logic                      rsp_last,
   output imm_pkg::tag_type          issue,
   output logic [ADDR_W-1:0]         a_addr,
   output logic [ADDR_W-1:0]         b_addr
);
   import imm_pkg::*;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end
      return r;
   endfunction

   seq_state_type    state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   dims_type         dims_ff, dims_in;
   logic             i_last, j_last, k_last, elem_last;

   assign i_last    = (DIM_W'(i_ff) + DIM_W'(1)) == dims_ff.rows_a;
   assign j_last    = (DIM_W'(j_ff) + DIM_W'(1)) == dims_ff.cols_b;
   assign k_last    = (DIM_W'(k_ff) + DIM_W'(1)) == dims_ff.inner_dim;
   assign elem_last = i_last && j_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         dims_ff  <= '{rows_a: DIM_RESET, inner_dim: DIM_RESET, cols_b: DIM_RESET};
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         dims_ff  <= dims_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE:   if (start) state_in = SEQ_ISSUE;
         SEQ_ISSUE:  if (k_last) state_in = SEQ_DRAIN;
         SEQ_DRAIN:  if (done) state_in = SEQ_OUTPUT;
         SEQ_OUTPUT: if (rsp_ready) state_in = elem_last ? SEQ_IDLE : SEQ_ISSUE;
         default:    state_in = SEQ_IDLE;
      endcase
   end

   // Index counters and latched dimensions
   always_comb begin
      i_in    = i_ff;
      j_in    = j_ff;
      k_in    = k_ff;
      dims_in = dims_ff;
      if (state_ff == SEQ_IDLE && start) begin
         i_in              = '0;
         j_in              = '0;
         k_in              = '0;
         dims_in.rows_a    = clamp_dim(dims.rows_a);
         dims_in.inner_dim = clamp_dim(dims.inner_dim);
         dims_in.cols_b    = clamp_dim(dims.cols_b);
      end else if (state_ff == SEQ_ISSUE) begin
         k_in = k_last ? '0 : k_ff + IDX_W'(1);
      end else if (state_ff == SEQ_OUTPUT && rsp_ready) begin
         if (j_last) begin
            j_in = '0;
            i_in = i_last ? '0 : i_ff + IDX_W'(1);
         end else begin
            j_in = j_ff + IDX_W'(1);
         end
      end
   end

   // Outputs
   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      issue.valid = 1'b0;
      issue.first = (k_ff == '0);
      issue.last  = k_last;
      unique case (state_ff)
         SEQ_IDLE:   req_ready   = !reset;
         SEQ_ISSUE:  issue.valid = 1'b1;
         SEQ_DRAIN:  ;
         SEQ_OUTPUT: rsp_valid   = 1'b1;
         default:    ;
      endcase
   end

   assign a_addr   = ADDR_W'(ADDR_W'(i_ff) * ADDR_W'(MAX_DIM) + ADDR_W'(k_ff));
   assign b_addr   = ADDR_W'(ADDR_W'(k_ff) * ADDR_W'(MAX_DIM) + ADDR_W'(j_ff));
   assign rsp_row  = ROW_W'(i_ff);
   assign rsp_col  = ROW_W'(j_ff);
   assign rsp_last = elem_last;

endmodule

/* sv/imm_mac.sv */
// Shared multiply-accumulate unit: product register, then 32-bit accumulator.
// Depends on imm_pkg for the tag type and element width.
`timescale 1ns / 1ps

module imm_mac (
   input  logic                        clock,
   input  logic                        reset,
   input  imm_pkg::tag_type            issue,
   input  logic [imm_pkg::VALUE_W-1:0] a_data,
   input  logic [imm_pkg::VALUE_W-1:0] b_data,
   output logic                        done,
   output logic [imm_pkg::VALUE_W-1:0] acc
);
   import imm_pkg::*;

   tag_type            s1_ff, s2_ff;
   logic [VALUE_W-1:0] prod_ff, prod_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;

   // Low word of the product is the same for signed and unsigned operands
   assign prod_in = a_data * b_data;

   always_comb begin
      acc_in = acc_ff;
      if (s2_ff.valid) begin
         acc_in = s2_ff.first ? prod_ff : acc_ff + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff  <= '0;
         s2_ff  <= '0;
         acc_ff <= '0;
      end else begin
         s1_ff  <= issue;
         s2_ff  <= s1_ff;
         acc_ff <= acc_in;
      end
      prod_ff <= prod_in;
   end

   assign done = s2_ff.valid && s2_ff.last;
   assign acc  = acc_ff;

endmodule

/* sv/integer_matrix_multiply.sv */
// Top level of the integer matrix multiplier: config registers, stores, wiring.
// Depends on imm_pkg, imm_ram, imm_seq, imm_mac and the assertion macro header.
`timescale 1ns / 1ps
`include "integer_matrix_multiply_macros.svh"

// Usage:
//  - csr_*: write rows_a (index 0), inner_dim (index 1) or cols_b (index 2), low
//    four bits of csr_data; other indexes are dropped. Ready whenever reset is
//    low; write only while the block is idle. A value of 0 acts as 1, above
//    MAX_DIM as MAX_DIM.
//  - req_*: one word loads one element of A or B at its row and column; loads
//    are taken one per cycle while idle. Indexes at or beyond MAX_DIM are not
//    stored. A word with load_last set is stored and then starts the product.
//  - rsp_*: the rows_a x cols_b result words in row-major order, out_last on the
//    final one. Each is the 32-bit wrapping dot product of a row of A and a
//    column of B.
//  - Timing: one shared multiplier and accumulator step through the inner index,
//    one term per cycle. Each result word passes the store read register, the
//    product register and the accumulator before it is valid; the next word is
//    started only after the previous word was taken.
//    req_ready stays low from the start until the last word is taken.
//  - A stalled receiver holds the current word; the sequencer waits on it.
//  - Reset: registers return to 2, the sequencer goes idle, no word is taken.
//    Stores keep no reset value; read only entries written since reset.
module integer_matrix_multiply #(
   parameter int MAX_DIM = imm_pkg::MAX_DIM_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  imm_pkg::req_word_type         req_word,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output imm_pkg::rsp_word_type         rsp_word,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [imm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [imm_pkg::CSR_DATA_W-1:0] csr_data
);
   import imm_pkg::*;

   localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
   localparam int LOAD_W = 2 * ROW_W;

   dims_type           dims_ff, dims_in;
   logic               req_fire, in_range;
   logic [ADDR_W-1:0]  load_addr, a_addr, b_addr;
   logic [VALUE_W-1:0] a_data, b_data, acc;
   tag_type            issue;
   logic               done;
   logic [ROW_W-1:0]   rsp_row, rsp_col;
   logic               rsp_last;

   // Configuration registers
   assign csr_ready = !reset;

   always_comb begin
      dims_in = dims_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROWS_A:    dims_in.rows_a    = DIM_W'(csr_data);
            CSR_INNER_DIM: dims_in.inner_dim = DIM_W'(csr_data);
            CSR_COLS_B:    dims_in.cols_b    = DIM_W'(csr_data);
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= '{rows_a: DIM_RESET, inner_dim: DIM_RESET, cols_b: DIM_RESET};
      end else begin
         dims_ff <= dims_in;
      end
   end

   // Load path: drop out-of-range indexes, keep load_last as a start
   assign req_fire  = req_valid && req_ready;
   assign in_range  = (DIM_W'(req_word.load_row) < DIM_W'(MAX_DIM)) &&
                      (DIM_W'(req_word.load_col) < DIM_W'(MAX_DIM));
   assign load_addr = ADDR_W'(LOAD_W'(req_word.load_row) * LOAD_W'(MAX_DIM) +
                              LOAD_W'(req_word.load_col));

   imm_ram #(.DEPTH(MAX_DIM * MAX_DIM), .ADDR_W(ADDR_W)) u_store_a (
      .clock   (clock),
      .wr_en   (req_fire && in_range && req_word.matrix_select == MATRIX_A),
      .wr_addr (load_addr),
      .wr_data (req_word.element_value),
      .rd_addr (a_addr),
      .rd_data (a_data)
   );

   imm_ram #(.DEPTH(MAX_DIM * MAX_DIM), .ADDR_W(ADDR_W)) u_store_b (
      .clock   (clock),
      .wr_en   (req_fire && in_range && req_word.matrix_select == MATRIX_B),
      .wr_addr (load_addr),
      .wr_data (req_word.element_value),
      .rd_addr (b_addr),
      .rd_data (b_data)
   );

   // Sequencer: one inner-index term per cycle, then wait for the result word
   imm_seq #(.MAX_DIM(MAX_DIM), .IDX_W(IDX_W), .ADDR_W(ADDR_W)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (req_fire && req_word.load_last),
      .dims      (dims_ff),
      .done      (done),
      .rsp_ready (rsp_ready),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_row   (rsp_row),
      .rsp_col   (rsp_col),
      .rsp_last  (rsp_last),
      .issue     (issue),
      .a_addr    (a_addr),
      .b_addr    (b_addr)
   );

   // Shared multiply-accumulate; the accumulator holds the word until taken
   imm_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .issue  (issue),
      .a_data (a_data),
      .b_data (b_data),
      .done   (done),
      .acc    (acc)
   );

   assign rsp_word.out_row       = rsp_row;
   assign rsp_word.out_col       = rsp_col;
   assign rsp_word.product_value = acc;
   assign rsp_word.out_last      = rsp_last;

   `IMM_ASSERT_NEVER(a_load_during_rsp, clock, reset, req_ready && rsp_valid, "load open during output")
   `IMM_ASSERT(a_start_blocks, clock, reset, (req_fire && req_word.load_last) |=> !req_ready, "load taken after start")
   `IMM_ASSERT(a_last_frees, clock, reset, (rsp_valid && rsp_ready && rsp_word.out_last) |=> req_ready, "not idle after last word")
   `IMM_ASSERT(a_mid_busy, clock, reset, (rsp_valid && rsp_ready && !rsp_word.out_last) |=> !req_ready, "idle before last word")

endmodule

/* dv/integer_matrix_multiply_tb.sv */
// Self-checking testbench for integer_matrix_multiply: loads A and B, checks every product word.
// Depends on imm_pkg and the integer_matrix_multiply RTL; nothing else is read.
`timescale 1ns / 1ps

module integer_matrix_multiply_tb;
   import imm_pkg::*;

   localparam int CELL_COUNT     = 64;
   localparam int ITEM_TARGET    = 360;
   localparam int SETTLE_CYCLES  = 16;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT   = 10;

   // Register index past the end of the list; the block drops writes to it
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_PERIODIC
   } ready_mode_type;

   // Mirror of the block: both stores, the three dimensions, and the queue of
   // product words still owed by the block.
   class product_tracker;
      logic [VALUE_W-1:0] a_cells[CELL_COUNT];
      logic [VALUE_W-1:0] b_cells[CELL_COUNT];
      logic [DIM_W-1:0]   rows_a;
      logic [DIM_W-1:0]   inner_dim;
      logic [DIM_W-1:0]   cols_b;
      rsp_word_type       owed_products[$];
      int                 mismatches;

      function new();
         rows_a     = DIM_RESET;
         inner_dim  = DIM_RESET;
         cols_b     = DIM_RESET;
         mismatches = 0;
         foreach (a_cells[n]) begin
            a_cells[n] = '0;
            b_cells[n] = '0;
         end
      endfunction

      // A zero acts as one, anything past the store size as the store size
      static function int clamp_dim(logic [DIM_W-1:0] raw);
         if (raw == 0) return 1;
         if (raw > MAX_DIM_DEFAULT) return MAX_DIM_DEFAULT;
         return int'(raw);
      endfunction

      function void write_dim(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_ROWS_A:    rows_a    = value;
            CSR_INNER_DIM: inner_dim = value;
            CSR_COLS_B:    cols_b    = value;
            default: ;
         endcase
      endfunction

      // Store the word; a word marked last then owes the whole product
      function void note_load(req_word_type w);
         int nr, nk, nc;
         logic [VALUE_W-1:0] acc;
         rsp_word_type exp_word;
         if (w.matrix_select == MATRIX_A) a_cells[{w.load_row, w.load_col}] = w.element_value;
         else b_cells[{w.load_row, w.load_col}] = w.element_value;
         if (!w.load_last) return;
         nr = clamp_dim(rows_a);
         nk = clamp_dim(inner_dim);
         nc = clamp_dim(cols_b);
         for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
               acc = '0;
               for (int k = 0; k < nk; k++)
                  acc = acc + a_cells[i * MAX_DIM_DEFAULT + k] * b_cells[k * MAX_DIM_DEFAULT + j];
               exp_word.out_row       = 3'(i);
               exp_word.out_col       = 3'(j);
               exp_word.product_value = acc;
               exp_word.out_last      = (i == nr - 1) && (j == nc - 1);
               owed_products.push_back(exp_word);
            end
         end
      endfunction

      function void check_product(rsp_word_type got);
         rsp_word_type exp_word;
         if (owed_products.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected product word: row %0d col %0d value %0d last %0d",
                        got.out_row, got.out_col, got.product_value, got.out_last);
            return;
         end
         exp_word = owed_products.pop_front();
         if (got !== exp_word) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("product mismatch: expected row %0d col %0d value %0d last %0d, %s",
                        exp_word.out_row, exp_word.out_col, exp_word.product_value,
                        exp_word.out_last,
                        $sformatf("got row %0d col %0d value %0d last %0d",
                                  got.out_row, got.out_col, got.product_value,
                                  got.out_last));
         end
      endfunction

      function int outstanding();
         return owed_products.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_word_type           req_word  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_word_type           rsp_word;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   product_tracker tracker = new();

   // Stimulus-side view: raw dimensions as written, and which cells hold data
   logic [DIM_W-1:0] dim_rows  = DIM_RESET;
   logic [DIM_W-1:0] dim_inner = DIM_RESET;
   logic [DIM_W-1:0] dim_cols  = DIM_RESET;
   bit               a_loaded[CELL_COUNT];
   bit               b_loaded[CELL_COUNT];
   int               items_sent  = 0;
   int               burst_left  = 0;
   int               idle_cycles = 0;

   // Receiver pattern state
   ready_mode_type   ready_mode   = READY_ALWAYS;
   int               stretch_left = 0;

   integer_matrix_multiply i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: hold one stall mode for a random stretch, then pick another.
   // The always-ready mode gives stretches with no stalls at all.
   always @(posedge clock) begin
      if (stretch_left == 0) begin
         ready_mode   = ready_mode_type'($urandom_range(0, 3));
         stretch_left = $urandom_range(5, 60);
      end
      stretch_left--;
      case (ready_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         READY_SPARSE: rsp_ready <= ($urandom_range(0, 5) == 0);
         default:      rsp_ready <= stretch_left[2];
      endcase
   end

   // Monitor: sample all three channels at the clock edge. Check results first,
   // so a result word and a load word at one edge are handled in a fixed order.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) tracker.check_product(rsp_word);
         if (csr_valid && csr_ready) tracker.write_dim(csr_index, csr_data);
         if (req_valid && req_ready) tracker.note_load(req_word);
      end
   end

   // Watchdog: end the run once no word has moved on any channel for too long
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   // Skew values toward the wrap corners; the rest are small or fully random
   function automatic logic [VALUE_W-1:0] random_value();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'hffff_ffff;
         3:       return 32'h0000_0000;
         4:       return 32'h0000_0001;
         5, 6:    return 32'($signed($urandom_range(0, 200)) - 100);
         default: return $urandom;
      endcase
   endfunction

   // Mostly small sizes; now and then the largest, a zero or an oversized value
   function automatic logic [DIM_W-1:0] random_dim();
      case ($urandom_range(0, 19))
         0:       return 4'd0;
         1:       return 4'd8;
         2:       return 4'($urandom_range(9, 15));
         default: return 4'($urandom_range(1, 4));
      endcase
   endfunction

   // Drop valid, let the owed product drain, then give the sequencer time to
   // go idle. The first edge lets the monitor note a last load at this edge.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Hold one register word until it is taken; the caller drops valid
   task automatic write_dim(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_dims(input logic [DIM_W-1:0] rows, inner, cols, input bit stray);
      settle();
      if (stray) write_dim(CSR_UNUSED, 4'($urandom));
      write_dim(CSR_ROWS_A, rows);
      write_dim(CSR_INNER_DIM, inner);
      write_dim(CSR_COLS_B, cols);
      csr_valid <= 1'b0;
      dim_rows  = rows;
      dim_inner = inner;
      dim_cols  = cols;
   endtask

   // Send one load word. The sender works in bursts: at the end of a burst,
   // drop valid for a random gap (sometimes none) before the next word.
   task automatic send_load(input logic sel, input logic [ROW_W-1:0] row, col,
                            input logic [VALUE_W-1:0] value, input logic last);
      req_word_type w;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      w.matrix_select = sel;
      w.load_row      = row;
      w.load_col      = col;
      w.element_value = value;
      w.load_last     = last;
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (sel == MATRIX_A) a_loaded[{row, col}] = 1'b1;
      else b_loaded[{row, col}] = 1'b1;
      items_sent++;
   endtask

   // One product: load the cells it reads (all of them, or only the missing
   // ones plus a few), mix in stray loads, shuffle, and mark the final word last.
   // Every cell the product reads is loaded by the time the last word lands.
   task automatic run_product();
      int nr, nk, nc, pick;
      bit full;
      logic [6:0] cells[$];
      logic [6:0] swap;
      nr   = product_tracker::clamp_dim(dim_rows);
      nk   = product_tracker::clamp_dim(dim_inner);
      nc   = product_tracker::clamp_dim(dim_cols);
      full = ($urandom_range(0, 9) < 7);
      for (int i = 0; i < nr; i++)
         for (int k = 0; k < nk; k++)
            if (full || !a_loaded[i * 8 + k] || $urandom_range(0, 7) == 0)
               cells.push_back({MATRIX_A, 3'(i), 3'(k)});
      for (int k = 0; k < nk; k++)
         for (int j = 0; j < nc; j++)
            if (full || !b_loaded[k * 8 + j] || $urandom_range(0, 7) == 0)
               cells.push_back({MATRIX_B, 3'(k), 3'(j)});
      repeat ($urandom_range(0, 4)) cells.push_back(7'($urandom));
      // Nothing missing: a lone word still carries the last flag and re-runs it
      if (cells.size() == 0) cells.push_back(7'($urandom));
      for (int n = cells.size() - 1; n > 0; n--) begin
         pick        = $urandom_range(0, n);
         swap        = cells[n];
         cells[n]    = cells[pick];
         cells[pick] = swap;
      end
      for (int n = 0; n < cells.size(); n++)
         send_load(cells[n][6], cells[n][5:3], cells[n][2:0], random_value(),
                   n == cells.size() - 1);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset sizes 2 x 2 x 2 with the wrap corners: max times max, min times
      // min, minus one and one, so both the products and the sums overflow.
      send_load(MATRIX_A, 3'd0, 3'd0, 32'h7fff_ffff, 1'b0);
      send_load(MATRIX_A, 3'd0, 3'd1, 32'h8000_0000, 1'b0);
      send_load(MATRIX_A, 3'd1, 3'd0, 32'hffff_ffff, 1'b0);
      send_load(MATRIX_A, 3'd1, 3'd1, 32'h0000_0001, 1'b0);
      send_load(MATRIX_B, 3'd0, 3'd0, 32'h7fff_ffff, 1'b0);
      send_load(MATRIX_B, 3'd0, 3'd1, 32'hffff_ffff, 1'b0);
      send_load(MATRIX_B, 3'd1, 3'd0, 32'h8000_0000, 1'b0);
      send_load(MATRIX_B, 3'd1, 3'd1, 32'h0000_0000, 1'b1);

      // Zero rows act as one, fifteen columns act as eight; a write to the
      // unused index must change nothing. Touch the far corner of both stores.
      set_dims(4'd0, 4'd1, 4'd15, 1'b1);
      send_load(MATRIX_A, 3'd7, 3'd7, 32'h8000_0000, 1'b0);
      send_load(MATRIX_B, 3'd7, 3'd7, 32'h7fff_ffff, 1'b0);
      for (int j = 2; j < 8; j++)
         send_load(MATRIX_B, 3'd0, 3'(j), random_value(), j == 7);

      // Single cell: the last word itself is the only operand that changes
      set_dims(4'd1, 4'd1, 4'd1, 1'b0);
      send_load(MATRIX_A, 3'd0, 3'd0, 32'h8000_0000, 1'b1);

      // Largest product once, then random phases. About half keep the sizes
      // and send the next words while the block is still busy with the product.
      set_dims(4'd8, 4'd8, 4'd8, 1'b0);
      run_product();
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 1) == 0)
            set_dims(random_dim(), random_dim(), random_dim(), $urandom_range(0, 3) == 0);
         run_product();
      end

      settle();
      if (tracker.mismatches == 0 && tracker.outstanding() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
